FILE: src/ofp_pkg.sv
// ----------------------------------------------------------------------------
// ofp_pkg
// Shared constants and types for the face line parser: character codes,
// parser phase and part codes, record kinds and the queue entry control word.
// ----------------------------------------------------------------------------
package ofp_pkg;

    localparam int INDEX_WIDTH_DEF = 24;
    localparam int COUNT_WIDTH_DEF = 16;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int FACE_SIZE_WIDTH = 16;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic REC_CORNER = 1'b0;
    localparam logic REC_END    = 1'b1;

    typedef enum logic [1:0] {
        PH_BETWEEN,
        PH_START,
        PH_DIGITS,
        PH_SKIP
    } phase_t;

    typedef enum logic [1:0] {
        PART_POS,
        PART_TEX,
        PART_NORM
    } part_t;

    typedef struct packed {
        logic                       has_corner;
        logic                       triple;
        logic                       has_end;
        logic [FACE_SIZE_WIDTH-1:0] face_size;
    } entry_ctrl_t;

endpackage

FILE: src/ofp_if.sv
// ----------------------------------------------------------------------------
// ofp_in_if / ofp_out_if
// Valid/ready channels for the face line parser: text bytes in, records out.
// ----------------------------------------------------------------------------
interface ofp_in_if #(
    parameter int INDEX_WIDTH = ofp_pkg::INDEX_WIDTH_DEF
) ();
    logic                 valid;
    logic                 ready;
    logic [7:0]           text_byte;
    logic [INDEX_WIDTH:0] vertex_count;
    logic [INDEX_WIDTH:0] texcoord_count;
    logic [INDEX_WIDTH:0] normal_count;

    modport source (
        output valid, text_byte, vertex_count, texcoord_count, normal_count,
        input  ready
    );
    modport sink (
        input  valid, text_byte, vertex_count, texcoord_count, normal_count,
        output ready
    );
endinterface

interface ofp_out_if #(
    parameter int INDEX_WIDTH = ofp_pkg::INDEX_WIDTH_DEF
) ();
    logic                                valid;
    logic                                ready;
    logic                                record_kind;
    logic [INDEX_WIDTH-1:0]              pos_index;
    logic                                pos_present;
    logic [INDEX_WIDTH-1:0]              tex_index;
    logic                                tex_present;
    logic [INDEX_WIDTH-1:0]              normal_index;
    logic                                normal_present;
    logic                                index_error;
    logic [ofp_pkg::FACE_SIZE_WIDTH-1:0] face_size;
    logic                                run_last;

    modport source (
        output valid, record_kind, pos_index, pos_present, tex_index, tex_present,
               normal_index, normal_present, index_error, face_size, run_last,
        input  ready
    );
    modport sink (
        input  valid, record_kind, pos_index, pos_present, tex_index, tex_present,
               normal_index, normal_present, index_error, face_size, run_last,
        output ready
    );
endinterface

FILE: src/ofp_front.sv
// ----------------------------------------------------------------------------
// ofp_front
// Byte parser: splits corners into parts, fixes indices, tracks the first
// and previous corner and pushes one queue entry per byte that yields records.
// ----------------------------------------------------------------------------
module ofp_front #(
    parameter int INDEX_WIDTH = ofp_pkg::INDEX_WIDTH_DEF,
    parameter int COUNT_WIDTH = ofp_pkg::COUNT_WIDTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wr_en,
    input  logic                     cfg_wr_data,
    ofp_in_if.sink                   text_in,
    input  logic                     queue_full,
    output logic                     push,
    output ofp_pkg::entry_ctrl_t     push_ctrl,
    output logic [3*INDEX_WIDTH+3:0] push_cur,
    output logic [3*INDEX_WIDTH+3:0] push_first,
    output logic [3*INDEX_WIDTH+3:0] push_prev
);
    import ofp_pkg::*;

    localparam int AW = INDEX_WIDTH + 1;
    localparam int PW = AW + 4;
    localparam logic [AW-1:0] MAG_MAX = {1'b1, {INDEX_WIDTH{1'b0}}};
    localparam logic [INDEX_WIDTH-1:0] IDX_MAX = '1;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic                        err;
        logic [2:0]                  present;
        logic [2:0][INDEX_WIDTH-1:0] idx;
    } corner_t;

    logic                  triangulate_reg;
    phase_t                phase_reg, phase_next;
    part_t                 stage_reg, stage_next;
    logic [AW-1:0]         acc_reg, acc_next;
    logic                  neg_reg, neg_next;
    logic [2:0][AW-1:0]    raw_reg, raw_next;
    logic [2:0]            given_reg, given_next;
    corner_t               first_reg, first_next;
    corner_t               prev_reg, prev_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;

    logic               accept;
    logic               is_end, is_delim, is_slash, is_digit;
    logic [3:0]         digit_val;
    logic               starting;
    phase_t             cur_phase;
    part_t              cur_stage;
    logic [AW-1:0]      cur_acc;
    logic               cur_neg;
    logic [2:0][AW-1:0] cur_raw;
    logic [2:0]         cur_given;
    logic [1:0]         sidx;
    logic [2:0][AW-1:0] counts;
    logic [AW-1:0]      sel_count;
    logic [AW-1:0]      diff, acc_dec;
    logic [AW-1:0]      fin_raw;
    logic [PW-1:0]      prod;
    logic [AW-1:0]      acc_digit;
    logic [2:0][AW-1:0] merged_raw;
    logic [2:0]         merged_given;
    corner_t            cur_corner;
    logic [COUNT_WIDTH-1:0] count_inc;
    logic [COUNT_WIDTH-1:0] count_after;
    logic [31:0]        count_ext;
    logic               emit_corner;

    // actions decoded from the byte and the parser phase
    logic   act_idle, act_finish, act_complete, act_end, act_restart, act_begin;
    part_t  begin_stage;
    logic   act_neg, act_pos, act_first_digit, act_digit, act_skip;

    assign accept         = text_in.valid && text_in.ready;
    assign text_in.ready  = !queue_full;

    assign is_end    = (text_in.text_byte == CHAR_LF) || (text_in.text_byte == CHAR_NUL);
    assign is_delim  = (text_in.text_byte == CHAR_SPACE) || (text_in.text_byte == CHAR_TAB)
                       || (text_in.text_byte == CHAR_CR);
    assign is_slash  = (text_in.text_byte == CHAR_SLASH);
    assign is_digit  = (text_in.text_byte >= CHAR_ZERO) && (text_in.text_byte <= CHAR_NINE);
    assign digit_val = 4'(text_in.text_byte - CHAR_ZERO);

    // a byte between corners that is neither a delimiter nor a line end opens a fresh corner
    assign starting  = (phase_reg == PH_BETWEEN);
    assign cur_phase = starting ? PH_START : phase_reg;
    assign cur_stage = starting ? PART_POS : stage_reg;
    assign cur_acc   = starting ? '0 : acc_reg;
    assign cur_neg   = starting ? 1'b0 : neg_reg;
    assign cur_raw   = starting ? '0 : raw_reg;
    assign cur_given = starting ? '0 : given_reg;

    assign counts[0] = text_in.vertex_count;
    assign counts[1] = text_in.texcoord_count;
    assign counts[2] = text_in.normal_count;

    always_comb
    begin
        unique case (cur_stage)
            PART_POS: sidx = 2'd0;
            PART_TEX: sidx = 2'd1;
            default:  sidx = 2'd2;
        endcase
    end

    assign sel_count = counts[sidx];
    assign diff      = sel_count - cur_acc;
    assign acc_dec   = cur_acc - AW'(1);

    // index fix of the part being closed; error flag sits above the index
    always_comb
    begin
        if (cur_acc == '0)
            fin_raw = '0;
        else if (!cur_neg)
            fin_raw = {1'b0, acc_dec[INDEX_WIDTH-1:0]};
        else if (cur_acc > sel_count)
            fin_raw = MAG_MAX;
        else if (diff[INDEX_WIDTH])
            fin_raw = {1'b0, IDX_MAX};
        else
            fin_raw = {1'b0, diff[INDEX_WIDTH-1:0]};
    end

    // acc * 10 + digit, saturating at the magnitude limit
    assign prod = ({4'b0, cur_acc} << 3) + ({4'b0, cur_acc} << 1) + PW'(digit_val);
    assign acc_digit = (prod > {4'b0, MAG_MAX}) ? MAG_MAX : prod[AW-1:0];

    always_comb
    begin
        act_idle        = 1'b0;
        act_finish      = 1'b0;
        act_complete    = 1'b0;
        act_end         = 1'b0;
        act_restart     = 1'b0;
        act_begin       = 1'b0;
        begin_stage     = PART_TEX;
        act_neg         = 1'b0;
        act_pos         = 1'b0;
        act_first_digit = 1'b0;
        act_digit       = 1'b0;
        act_skip        = 1'b0;
        if (starting && is_end)
            act_end = 1'b1;
        else if (starting && is_delim)
            act_idle = 1'b1;
        else if (is_end || is_delim)
        begin
            act_finish   = 1'b1;
            act_complete = 1'b1;
            act_end      = is_end;
        end
        else if (is_slash)
        begin
            unique case (cur_stage)
                PART_POS:
                begin
                    act_finish  = 1'b1;
                    act_begin   = 1'b1;
                    begin_stage = PART_TEX;
                end
                PART_TEX:
                begin
                    // "//" leaves the texcoord part absent
                    act_finish  = (cur_phase != PH_START);
                    act_begin   = 1'b1;
                    begin_stage = PART_NORM;
                end
                default:
                begin
                    // slash after the normal closes the corner and opens another
                    act_finish   = 1'b1;
                    act_complete = 1'b1;
                    act_restart  = 1'b1;
                end
            endcase
        end
        else
        begin
            unique case (cur_phase)
                PH_START:
                begin
                    if (text_in.text_byte == CHAR_MINUS)
                        act_neg = 1'b1;
                    else if (text_in.text_byte == CHAR_PLUS)
                        act_pos = 1'b1;
                    else if (is_digit)
                        act_first_digit = 1'b1;
                    else
                        act_skip = 1'b1;
                end
                PH_DIGITS:
                begin
                    if (is_digit)
                        act_digit = 1'b1;
                    else
                        act_skip = 1'b1;
                end
                default:
                begin
                    act_skip = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        merged_raw   = cur_raw;
        merged_given = cur_given;
        if (act_finish)
        begin
            merged_raw[sidx]   = fin_raw;
            merged_given[sidx] = 1'b1;
        end
    end

    always_comb
    begin
        cur_corner.err = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            cur_corner.present[i] = merged_given[i];
            cur_corner.idx[i]     = merged_given[i] ? merged_raw[i][INDEX_WIDTH-1:0] : '0;
            cur_corner.err        = cur_corner.err | (merged_given[i] & merged_raw[i][INDEX_WIDTH]);
        end
    end

    assign count_inc = (count_reg != COUNT_MAX) ? count_reg + COUNT_WIDTH'(1) : count_reg;

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        stage_next = stage_reg;
        acc_next   = acc_reg;
        neg_next   = neg_reg;
        raw_next   = raw_reg;
        given_next = given_reg;
        first_next = first_reg;
        prev_next  = prev_reg;
        count_next = count_reg;
        if (accept && act_end)
        begin
            phase_next = PH_BETWEEN;
            stage_next = PART_POS;
            acc_next   = '0;
            neg_next   = 1'b0;
            raw_next   = '0;
            given_next = '0;
            first_next = '0;
            prev_next  = '0;
            count_next = '0;
        end
        else if (accept && !act_idle)
        begin
            phase_next = cur_phase;
            stage_next = cur_stage;
            acc_next   = cur_acc;
            neg_next   = cur_neg;
            raw_next   = merged_raw;
            given_next = merged_given;
            if (act_begin)
            begin
                stage_next = begin_stage;
                phase_next = PH_START;
                acc_next   = '0;
                neg_next   = 1'b0;
            end
            if (act_complete)
            begin
                if (count_reg == '0)
                    first_next = cur_corner;
                prev_next  = cur_corner;
                count_next = count_inc;
                phase_next = PH_BETWEEN;
            end
            if (act_restart)
            begin
                raw_next   = '0;
                given_next = 3'b001;
                stage_next = PART_TEX;
                phase_next = PH_START;
                acc_next   = '0;
                neg_next   = 1'b0;
            end
            if (act_neg)
            begin
                neg_next   = 1'b1;
                phase_next = PH_DIGITS;
            end
            if (act_pos)
                phase_next = PH_DIGITS;
            if (act_first_digit)
            begin
                acc_next   = AW'(digit_val);
                phase_next = PH_DIGITS;
            end
            if (act_digit)
                acc_next = acc_digit;
            if (act_skip)
                phase_next = PH_SKIP;
        end
    end

    // queue entry
    assign count_after = act_complete ? count_inc : count_reg;
    assign count_ext   = 32'(count_after);
    assign emit_corner = act_complete && (!triangulate_reg || (count_reg > COUNT_WIDTH'(1)));

    always_comb
    begin
        push                 = accept && (emit_corner || act_end);
        push_ctrl.has_corner = emit_corner;
        push_ctrl.triple     = triangulate_reg;
        push_ctrl.has_end    = act_end;
        push_ctrl.face_size  = (count_ext > 32'hFFFF) ? '1 : count_ext[FACE_SIZE_WIDTH-1:0];
        push_cur             = cur_corner;
        push_first           = (count_reg == '0) ? cur_corner : first_reg;
        push_prev            = prev_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            triangulate_reg <= 1'b1;
            phase_reg       <= PH_BETWEEN;
            stage_reg       <= PART_POS;
            acc_reg         <= '0;
            neg_reg         <= 1'b0;
            raw_reg         <= '0;
            given_reg       <= '0;
            first_reg       <= '0;
            prev_reg        <= '0;
            count_reg       <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                triangulate_reg <= cfg_wr_data;
            phase_reg <= phase_next;
            stage_reg <= stage_next;
            acc_reg   <= acc_next;
            neg_reg   <= neg_next;
            raw_reg   <= raw_next;
            given_reg <= given_next;
            first_reg <= first_next;
            prev_reg  <= prev_next;
            count_reg <= count_next;
        end
    end

endmodule

FILE: src/ofp_queue.sv
// ----------------------------------------------------------------------------
// ofp_queue
// Small register FIFO between the parser and the record sequencer.
// ----------------------------------------------------------------------------
module ofp_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = ofp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output logic [WIDTH-1:0] head_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

FILE: src/ofp_back.sv
// ----------------------------------------------------------------------------
// ofp_back
// Record sequencer: walks one queue entry into its corner and end records
// and holds each in the output register until transferred.
// ----------------------------------------------------------------------------
module ofp_back #(
    parameter int INDEX_WIDTH = ofp_pkg::INDEX_WIDTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     head_valid,
    input  ofp_pkg::entry_ctrl_t     head_ctrl,
    input  logic [3*INDEX_WIDTH+3:0] head_cur,
    input  logic [3*INDEX_WIDTH+3:0] head_first,
    input  logic [3*INDEX_WIDTH+3:0] head_prev,
    output logic                     pop,
    ofp_out_if.source                record_out
);
    import ofp_pkg::*;

    typedef struct packed {
        logic                        err;
        logic [2:0]                  present;
        logic [2:0][INDEX_WIDTH-1:0] idx;
    } corner_t;

    logic [1:0]                 step_reg, step_next;
    logic                       valid_reg;
    logic                       kind_reg;
    corner_t                    corner_reg;
    logic [FACE_SIZE_WIDTH-1:0] face_reg;
    logic                       last_reg;

    logic [2:0] n_corner, n_rec;
    logic       is_corner, is_last, out_free, load;
    corner_t    sel_corner;

    assign n_corner  = !head_ctrl.has_corner ? 3'd0 : (head_ctrl.triple ? 3'd3 : 3'd1);
    assign n_rec     = n_corner + {2'b0, head_ctrl.has_end};
    assign is_corner = ({1'b0, step_reg} < n_corner);
    assign is_last   = (({1'b0, step_reg} + 3'd1) == n_rec);
    assign out_free  = !valid_reg || record_out.ready;
    assign load      = out_free && head_valid;
    assign pop       = load && is_last;

    // fan order is first, previous, current
    always_comb
    begin
        if (!head_ctrl.triple)
            sel_corner = head_cur;
        else
        begin
            case (step_reg)
                2'd0:    sel_corner = head_first;
                2'd1:    sel_corner = head_prev;
                default: sel_corner = head_cur;
            endcase
        end
    end

    assign step_next = is_last ? 2'd0 : step_reg + 2'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            step_reg  <= 2'd0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            step_reg  <= step_next;
        end
        else if (record_out.ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg   <= is_corner ? REC_CORNER : REC_END;
            corner_reg <= is_corner ? sel_corner : '0;
            face_reg   <= is_corner ? '0 : head_ctrl.face_size;
            last_reg   <= is_last;
        end
    end

    assign record_out.valid          = valid_reg;
    assign record_out.record_kind    = kind_reg;
    assign record_out.pos_index      = corner_reg.idx[0];
    assign record_out.pos_present    = corner_reg.present[0];
    assign record_out.tex_index      = corner_reg.idx[1];
    assign record_out.tex_present    = corner_reg.present[1];
    assign record_out.normal_index   = corner_reg.idx[2];
    assign record_out.normal_present = corner_reg.present[2];
    assign record_out.index_error    = corner_reg.err;
    assign record_out.face_size      = face_reg;
    assign record_out.run_last       = last_reg;

endmodule

FILE: src/obj_face_line_parser.sv
// ----------------------------------------------------------------------------
// obj_face_line_parser
// Face line corner parser with optional fan triangulation.
//
//   channel      dir  handshake      payload
//   text_in      in   valid/ready    text_byte, vertex/texcoord/normal counts
//   record_out   out  valid/ready    record fields, face_size, run_last
//   cfg_wr_*     in   write enable   triangulate
//
// One text byte per cycle is taken while the entry queue has room.
// The record sequencer sends one record per cycle while record_out is ready,
// so a byte that closes a triangle and the face yields four records there;
// the queue soaks this up. State is set by reset; there is no clearing pass.
// A stalled record_out fills the queue and then drops text_in.ready.
// ----------------------------------------------------------------------------
module obj_face_line_parser #(
    parameter int INDEX_WIDTH = ofp_pkg::INDEX_WIDTH_DEF,
    parameter int COUNT_WIDTH = ofp_pkg::COUNT_WIDTH_DEF,
    parameter int QUEUE_DEPTH = ofp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    ofp_in_if.sink     text_in,
    ofp_out_if.source  record_out
);
    import ofp_pkg::*;

    localparam int CW = 3 * INDEX_WIDTH + 4;
    localparam int EW = $bits(entry_ctrl_t) + 3 * CW;

    logic              push, pop, queue_full, head_valid;
    entry_ctrl_t       push_ctrl, head_ctrl;
    logic [CW-1:0]     push_cur, push_first, push_prev;
    logic [CW-1:0]     head_cur, head_first, head_prev;
    logic [EW-1:0]     push_data, head_data;

    ofp_front #(
        .INDEX_WIDTH (INDEX_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .text_in     (text_in),
        .queue_full  (queue_full),
        .push        (push),
        .push_ctrl   (push_ctrl),
        .push_cur    (push_cur),
        .push_first  (push_first),
        .push_prev   (push_prev)
    );

    assign push_data = {push_ctrl, push_cur, push_first, push_prev};

    ofp_queue #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    assign {head_ctrl, head_cur, head_first, head_prev} = head_data;

    ofp_back #(
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_ctrl  (head_ctrl),
        .head_cur   (head_cur),
        .head_first (head_first),
        .head_prev  (head_prev),
        .pop        (pop),
        .record_out (record_out)
    );

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the face line parser. Text bytes go in over a valid/ready
// channel with random gaps; records are taken with random stalls and checked
// field by field against a parser model held in a small scoreboard class.
// Covers fan and pass-through modes, relative and out-of-range indices, saturation
// and a back-to-back fan face at the end.
// ----------------------------------------------------------------------------
module tb_top;
    import ofp_pkg::*;

    localparam int IW = INDEX_WIDTH_DEF;
    localparam int CW = COUNT_WIDTH_DEF;
    localparam logic [IW:0] MAG_MAX = {1'b1, {IW{1'b0}}};
    localparam logic [IW:0] IDX_MAX = {1'b0, {IW{1'b1}}};
    localparam logic [CW-1:0] COUNT_MAX = '1;
    localparam int QUIET_CYCLES = 12;

    typedef struct packed {
        logic [2:0][IW-1:0] idx;
        logic [2:0]         given;
        logic               err;
    } corner_t;

    typedef struct packed {
        logic                       kind;
        logic [IW-1:0]              pos;
        logic                       pos_given;
        logic [IW-1:0]              tex;
        logic                       tex_given;
        logic [IW-1:0]              nrm;
        logic                       nrm_given;
        logic                       err;
        logic [FACE_SIZE_WIDTH-1:0] size;
        logic                       last;
    } record_t;

    class face_record_board;
        record_t           expected_records[$];
        logic              fan_mode = 1'b1;
        part_t             part;
        phase_t            phase;
        logic [IW:0]       acc;
        logic              negative;
        logic [2:0][IW:0]  raw;
        logic [2:0]        given;
        corner_t           first_corner;
        corner_t           prev_corner;
        logic [CW-1:0]     corners;
        int                bytes_parsed = 0;
        int                records_checked = 0;
        int                faces_closed = 0;
        int                mismatches = 0;

        function new();
            reset_face();
        endfunction

        function void set_mode(logic fan);
            fan_mode = fan;
        endfunction

        function int pending();
            return expected_records.size();
        endfunction

        function void reset_face();
            part         = PART_POS;
            phase        = PH_BETWEEN;
            acc          = '0;
            negative     = 1'b0;
            raw          = '0;
            given        = '0;
            first_corner = '0;
            prev_corner  = '0;
            corners      = '0;
        endfunction

        function void close_face();
            record_t rec;
            rec      = '0;
            rec.kind = REC_END;
            rec.size = corners;
            expected_records.push_back(rec);
            reset_face();
        endfunction

        function void open_part(part_t p);
            part     = p;
            phase    = PH_START;
            acc      = '0;
            negative = 1'b0;
        endfunction

        function void close_part(part_t p, logic [2:0][IW:0] counts);
            logic [IW:0] r;
            logic        e;
            r = '0;
            e = 1'b0;
            if (acc == 0)
                r = '0;
            else if (!negative)
                r = acc - 1'b1;
            else if (acc > counts[p])
                e = 1'b1;
            else
            begin
                r = counts[p] - acc;
                if (r > IDX_MAX)
                    r = IDX_MAX;
            end
            raw[p]   = {e, r[IW-1:0]};
            given[p] = 1'b1;
        endfunction

        function void emit(corner_t c);
            record_t rec;
            rec           = '0;
            rec.kind      = REC_CORNER;
            rec.pos       = c.idx[PART_POS];
            rec.pos_given = c.given[PART_POS];
            rec.tex       = c.idx[PART_TEX];
            rec.tex_given = c.given[PART_TEX];
            rec.nrm       = c.idx[PART_NORM];
            rec.nrm_given = c.given[PART_NORM];
            rec.err       = c.err;
            expected_records.push_back(rec);
        endfunction

        function void complete_corner();
            corner_t cur;
            int      i;
            cur = '0;
            for (i = 0; i < 3; i++)
            begin
                if (given[i])
                begin
                    cur.given[i] = 1'b1;
                    cur.idx[i]   = raw[i][IW-1:0];
                    cur.err      = cur.err | raw[i][IW];
                end
            end
            if (corners == 0)
                first_corner = cur;
            if (fan_mode)
            begin
                if (corners >= 2)
                begin
                    emit(first_corner);
                    emit(prev_corner);
                    emit(cur);
                end
            end
            else
                emit(cur);
            prev_corner = cur;
            if (corners != COUNT_MAX)
                corners++;
            phase = PH_BETWEEN;
        endfunction

        function void parse_byte(logic [7:0] b, logic [2:0][IW:0] counts);
            logic        is_delim;
            logic        is_end;
            logic [31:0] grown;
            int          queued_at_start;
            record_t     rec;
            queued_at_start = expected_records.size();
            is_delim = (b == CHAR_SPACE || b == CHAR_TAB || b == CHAR_CR);
            is_end   = (b == CHAR_LF || b == CHAR_NUL);
            bytes_parsed++;
            if (phase == PH_BETWEEN && is_end)
                close_face();
            else if (!(phase == PH_BETWEEN && is_delim))
            begin
                if (phase == PH_BETWEEN)
                begin
                    raw   = '0;
                    given = '0;
                    open_part(PART_POS);
                end
                if (is_end || is_delim)
                begin
                    close_part(part, counts);
                    complete_corner();
                    if (is_end)
                        close_face();
                end
                else if (b == CHAR_SLASH)
                begin
                    case (part)
                        PART_POS:
                        begin
                            close_part(PART_POS, counts);
                            open_part(PART_TEX);
                        end
                        PART_TEX:
                        begin
                            if (phase != PH_START)
                                close_part(PART_TEX, counts);
                            open_part(PART_NORM);
                        end
                        default:
                        begin
                            // a slash in the normal part starts a corner with an empty position
                            close_part(PART_NORM, counts);
                            complete_corner();
                            raw   = '0;
                            given = '0;
                            open_part(PART_POS);
                            close_part(PART_POS, counts);
                            open_part(PART_TEX);
                        end
                    endcase
                end
                else if (phase == PH_START)
                begin
                    if (b == CHAR_MINUS)
                    begin
                        negative = 1'b1;
                        phase    = PH_DIGITS;
                    end
                    else if (b == CHAR_PLUS)
                        phase = PH_DIGITS;
                    else if (b >= CHAR_ZERO && b <= CHAR_NINE)
                    begin
                        acc   = (IW+1)'(b - CHAR_ZERO);
                        phase = PH_DIGITS;
                    end
                    else
                        phase = PH_SKIP;
                end
                else if (phase == PH_DIGITS)
                begin
                    if (b >= CHAR_ZERO && b <= CHAR_NINE)
                    begin
                        grown = 32'(acc) * 32'd10 + 32'(b - CHAR_ZERO);
                        acc   = (grown > 32'(MAG_MAX)) ? MAG_MAX : grown[IW:0];
                    end
                    else
                        phase = PH_SKIP;
                end
            end
            if (expected_records.size() > queued_at_start)
            begin
                rec      = expected_records.pop_back();
                rec.last = 1'b1;
                expected_records.push_back(rec);
            end
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_record(record_t got);
            record_t want;
            if (expected_records.size() == 0)
            begin
                $display("%0t: record with none expected, actual %h", $time, got);
                mismatches++;
                return;
            end
            want = expected_records.pop_front();
            records_checked++;
            if (want.kind == REC_END)
                faces_closed++;
            compare_field("record_kind", 32'(want.kind), 32'(got.kind));
            compare_field("pos_index", 32'(want.pos), 32'(got.pos));
            compare_field("pos_present", 32'(want.pos_given), 32'(got.pos_given));
            compare_field("tex_index", 32'(want.tex), 32'(got.tex));
            compare_field("tex_present", 32'(want.tex_given), 32'(got.tex_given));
            compare_field("normal_index", 32'(want.nrm), 32'(got.nrm));
            compare_field("normal_present", 32'(want.nrm_given), 32'(got.nrm_given));
            compare_field("index_error", 32'(want.err), 32'(got.err));
            compare_field("face_size", 32'(want.size), 32'(got.size));
            compare_field("run_last", 32'(want.last), 32'(got.last));
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    logic cfg_wr_data;
    bit   idle_on = 1'b1;

    logic [7:0] face_text[$];

    ofp_in_if  text_in ();
    ofp_out_if record_out ();

    face_record_board board = new();

    obj_face_line_parser DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .text_in     (text_in),
        .record_out  (record_out)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    initial
    begin
        rst_n <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #2000000;
        $display("FAIL obj_face_line_parser");
        $finish;
    end

    // both channels sampled at the edge; input side first so a transfer's
    // records are predicted before any of them can be checked
    always @(posedge clk)
    begin
        record_t seen;
        if (rst_n === 1'b1)
        begin
            if (text_in.valid === 1'b1 && text_in.ready === 1'b1)
                board.parse_byte(text_in.text_byte,
                    {text_in.normal_count, text_in.texcoord_count, text_in.vertex_count});
            if (record_out.valid === 1'b1 && record_out.ready === 1'b1)
            begin
                seen.kind      = record_out.record_kind;
                seen.pos       = record_out.pos_index;
                seen.pos_given = record_out.pos_present;
                seen.tex       = record_out.tex_index;
                seen.tex_given = record_out.tex_present;
                seen.nrm       = record_out.normal_index;
                seen.nrm_given = record_out.normal_present;
                seen.err       = record_out.index_error;
                seen.size      = record_out.face_size;
                seen.last      = record_out.run_last;
                board.check_record(seen);
            end
        end
    end

    // record sink with random stall bursts
    initial
    begin
        int stall_left;
        stall_left = 0;
        record_out.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                record_out.ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 10) - 1;
                record_out.ready <= 1'b0;
            end
            else
                record_out.ready <= 1'b1;
        end
    end

    function automatic logic [IW:0] random_count();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return MAG_MAX;
            2: return (IW+1)'($urandom_range(0, 32'(MAG_MAX)));
            default: return (IW+1)'($urandom_range(0, 12));
        endcase
    endfunction

    function automatic logic [7:0] pick_delim();
        case ($urandom_range(0, 2))
            0: return CHAR_SPACE;
            1: return CHAR_TAB;
            default: return CHAR_CR;
        endcase
    endfunction

    function automatic void add_number();
        int sel;
        int k;
        sel = $urandom_range(0, 19);
        if (sel == 0)
            return;
        if (sel < 5)
            face_text.push_back(CHAR_MINUS);
        else if (sel == 5)
            face_text.push_back(CHAR_PLUS);
        for (k = (sel == 6) ? $urandom_range(7, 9) : $urandom_range(1, 2); k > 0; k--)
            face_text.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
        // trailing junk is skipped up to the next separator
        if (sel == 7)
            face_text.push_back(8'h61 + 8'($urandom_range(0, 25)));
    endfunction

    function automatic void add_face();
        int corners;
        int form;
        int k;
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 8)) face_text.push_back(8'($urandom_range(0, 255)));
            face_text.push_back(CHAR_LF);
            return;
        end
        corners = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 6);
        if ($urandom_range(0, 3) == 0)
            face_text.push_back(pick_delim());
        for (k = 0; k < corners; k++)
        begin
            if (k > 0)
                repeat ($urandom_range(1, 2)) face_text.push_back(pick_delim());
            form = $urandom_range(0, 8);
            add_number();
            if (form >= 2)
            begin
                face_text.push_back(CHAR_SLASH);
                if (form < 4 || form > 5)
                    add_number();
            end
            if (form >= 4)
            begin
                face_text.push_back(CHAR_SLASH);
                add_number();
            end
            if (form == 8)
            begin
                face_text.push_back(CHAR_SLASH);
                add_number();
            end
        end
        if ($urandom_range(0, 3) == 0)
            face_text.push_back(pick_delim());
        case ($urandom_range(0, 3))
            0: face_text.push_back(CHAR_LF);
            1: face_text.push_back(CHAR_NUL);
            2:
            begin
                face_text.push_back(CHAR_CR);
                face_text.push_back(CHAR_LF);
            end
            default:
            begin
                face_text.push_back(CHAR_CR);
                face_text.push_back(CHAR_NUL);
            end
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] value, input logic [IW:0] vc, tc, nc);
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            text_in.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        text_in.valid          <= 1'b1;
        text_in.text_byte      <= value;
        text_in.vertex_count   <= vc;
        text_in.texcoord_count <= tc;
        text_in.normal_count   <= nc;
        @(posedge clk);
        while (text_in.ready !== 1'b1) @(posedge clk);
    endtask

    task automatic send_string(input string s, input logic [IW:0] vc, tc, nc);
        int k;
        for (k = 0; k < s.len(); k++)
            send_byte(s[k], vc, tc, nc);
    endtask

    // carries on through the generated stream; a face may span two calls
    task automatic send_stream(input int count);
        int k;
        for (k = 0; k < count || (count < 0 && face_text.size() != 0); k++)
        begin
            if (face_text.size() == 0)
                add_face();
            send_byte(face_text.pop_front(), random_count(), random_count(), random_count());
        end
    endtask

    // drops valid and lets the clock tick first so the last transfer is already in the scoreboard
    task automatic wait_quiet();
        text_in.valid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0) @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(input logic fan);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= fan;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        board.set_mode(fan);
    endtask

    initial
    begin
        int phase_no;
        text_in.valid          <= 1'b0;
        text_in.text_byte      <= '0;
        text_in.vertex_count   <= '0;
        text_in.texcoord_count <= '0;
        text_in.normal_count   <= '0;
        cfg_wr_en              <= 1'b0;
        cfg_wr_data            <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);

        // fan mode: positive, relative and out-of-range indices, absent, skipped and
        // empty parts, CR before the line end
        write_mode(1'b1);
        send_string("1/2/3 -1//-9\t+2/x/", 5, 3, 2);
        send_byte(CHAR_CR, 5, 3, 2);
        send_byte(CHAR_LF, 5, 3, 2);
        wait_quiet();

        // pass-through: full-range counts, saturating magnitude, extra slash,
        // then an empty face
        write_mode(1'b0);
        send_string("-1/99999999//", MAG_MAX, MAG_MAX, 4);
        send_byte(CHAR_NUL, MAG_MAX, MAG_MAX, 4);
        send_byte(CHAR_LF, 0, 0, 0);
        wait_quiet();

        // random faces; mode flips between bursts, often mid-face
        for (phase_no = 0; phase_no < 3; phase_no++)
        begin
            write_mode((phase_no % 2) == 0);
            send_stream($urandom_range(10, 15));
            wait_quiet();
        end
        send_stream(-1);
        wait_quiet();

        // full rate to the end: one fan face sent back to back
        idle_on = 1'b0;
        write_mode(1'b1);
        send_string("3/1/2 -1//-3 5 2", 9, 9, 9);
        send_byte(CHAR_LF, 9, 9, 9);
        wait_quiet();

        $display("run covered %0d text bytes and %0d records over %0d faces",
                 board.bytes_parsed, board.records_checked, board.faces_closed);
        $display("both output modes, relative and clamped indices, saturation, stalls");
        if (board.mismatches == 0 && board.pending() == 0)
            $display("PASS obj_face_line_parser");
        else
            $display("FAIL obj_face_line_parser");
        $finish;
    end

endmodule
